### design/lbn_pkg.sv
// Shared types and constants for the luminance brightness normalizer.
// Used by lbn_front, lbn_queue, lbn_back and the top level; no dependencies.
package lbn_pkg;

    localparam int LUM_W      = 24;   // Q16 luminance of one 8-bit pixel
    localparam int CFG_IDX_W  = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] LUM_WR = 16'd19595;
    localparam logic [15:0] LUM_WG = 16'd38470;
    localparam logic [15:0] LUM_WB = 16'd7471;

    localparam logic [7:0]  CHAN_MAX   = 8'hFF;
    localparam logic [31:0] UNITY_GAIN = 32'h0001_0000;
    localparam logic [31:0] GAIN_MAX   = 32'hFFFF_FFFF;

    localparam logic [15:0] TARGET_RESET = 16'd32768;
    localparam logic [15:0] ADJUST_RESET = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST = 8'd1;

    typedef struct packed {
        logic [15:0] target;
        logic [15:0] adjust;
    } lbn_cfg_t;

    typedef struct packed {
        logic             apply;   // 1: apply pixel, 0: measure pixel
        logic             last;
        logic [LUM_W-1:0] lum;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
    } lbn_item_t;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_MUL_TA,
        GS_MUL_N,
        GS_CHECK,
        GS_DIV
    } gain_state_t;

    // (c * f) >> 16, saturated at 255
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [31:0] f);
        logic [39:0] p;
        p = 40'(c) * 40'(f);
        if (p[39:24] != 16'd0) begin
            return CHAN_MAX;
        end
        return p[23:16];
    endfunction

endpackage

### design/lbn_front.sv
// Front end: accepts input pixels, classifies them and computes Q16 luminance.
// Depends on lbn_pkg; feeds lbn_queue.
module lbn_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output lbn_pkg::lbn_item_t q_item
);
    import lbn_pkg::*;

    logic [7:0] red, green, blue;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.apply = s_tuser;
        q_item.last  = s_tlast && !s_tuser;   // last only matters on measure pixels
        q_item.lum   = LUM_W'(LUM_WR) * LUM_W'(red)
                     + LUM_W'(LUM_WG) * LUM_W'(green)
                     + LUM_W'(LUM_WB) * LUM_W'(blue);
        q_item.red   = red;
        q_item.green = green;
        q_item.blue  = blue;
        q_item.alpha = s_tdata[31:24];
    end

endmodule

### design/lbn_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on lbn_pkg.
module lbn_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lbn_pkg::lbn_item_t item_in,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output lbn_pkg::lbn_item_t item_out
);
    import lbn_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lbn_item_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign item_out = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

### design/lbn_back.sv
// Back end: accumulates luminance, computes the Q16.16 gain with a serial
// divider, and scales apply pixels into the output register. Depends on lbn_pkg.
module lbn_back #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lbn_pkg::lbn_cfg_t  cfg,
    input  logic               q_valid,
    input  lbn_pkg::lbn_item_t q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata
);
    import lbn_pkg::*;

    localparam int    CNT_W   = $clog2(MAX_PIXELS + 1);
    localparam longint SUM_MAX = longint'(MAX_PIXELS) * 64'd16711680;
    localparam int    SUM_W   = $clog2(SUM_MAX + 1);
    localparam int    TAC_W   = 32 + CNT_W;
    localparam int    NUM_W   = TAC_W + 12;
    localparam int    HI_W    = NUM_W - 32;
    localparam int    REM_W   = ((HI_W > SUM_W) ? HI_W : SUM_W) + 1;

    gain_state_t      state_reg, state_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      scale_reg, scale_next;
    logic [31:0]      ta_reg, ta_next;
    logic [TAC_W-1:0] tac_reg, tac_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [31:0]      q_reg, q_next;
    logic [4:0]       bit_cnt_reg, bit_cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg, m_data_next;

    logic [NUM_W-1:0] num;
    logic [31:0]      num_lo;
    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] sum_ext;
    logic             q_bit;

    assign num       = {tac_reg, 12'b0};
    assign num_lo    = num[31:0];
    assign sum_ext   = REM_W'(sum_reg);
    assign rem_shift = {rem_reg[REM_W-2:0], num_lo[bit_cnt_reg]};
    assign q_bit     = (rem_shift >= sum_ext);

    assign q_pop = q_valid && (state_reg == GS_IDLE)
                && (!q_item.apply || !m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        scale_next   = scale_reg;
        ta_next      = ta_reg;
        tac_next     = tac_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        bit_cnt_next = bit_cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            GS_IDLE: begin
                if (q_pop) begin
                    if (q_item.apply) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {q_item.alpha,
                                        scale_chan(q_item.blue, scale_reg),
                                        scale_chan(q_item.green, scale_reg),
                                        scale_chan(q_item.red, scale_reg)};
                    end else begin
                        if (count_reg < CNT_W'(MAX_PIXELS)) begin
                            sum_next   = sum_reg + SUM_W'(q_item.lum);
                            count_next = count_reg + 1'b1;
                        end
                        if (q_item.last) begin
                            state_next = GS_MUL_TA;
                        end
                    end
                end
            end
            GS_MUL_TA: begin
                ta_next    = 32'(cfg.target) * 32'(cfg.adjust);
                state_next = GS_MUL_N;
            end
            GS_MUL_N: begin
                tac_next   = TAC_W'(ta_reg) * TAC_W'(count_reg);
                state_next = GS_CHECK;
            end
            GS_CHECK: begin
                // all-black pass or quotient beyond 32 bits: saturate
                if (sum_reg == '0 || REM_W'(num[NUM_W-1:32]) >= sum_ext) begin
                    scale_next = GAIN_MAX;
                    sum_next   = '0;
                    count_next = '0;
                    state_next = GS_IDLE;
                end else begin
                    rem_next     = REM_W'(num[NUM_W-1:32]);
                    q_next       = '0;
                    bit_cnt_next = 5'd31;
                    state_next   = GS_DIV;
                end
            end
            GS_DIV: begin
                rem_next = q_bit ? (rem_shift - sum_ext) : rem_shift;
                q_next   = {q_reg[30:0], q_bit};
                if (bit_cnt_reg == 5'd0) begin
                    scale_next = {q_reg[30:0], q_bit};
                    sum_next   = '0;
                    count_next = '0;
                    state_next = GS_IDLE;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            default: begin
                state_next = GS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= GS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            count_reg   <= '0;
            scale_reg   <= UNITY_GAIN;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            scale_reg   <= scale_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ta_reg      <= ta_next;
        tac_reg     <= tac_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        bit_cnt_reg <= bit_cnt_next;
        m_data_reg  <= m_data_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count beyond limit");
    a_rem_below_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == GS_DIV |-> rem_reg < sum_ext)
        else $error("divider remainder not below divisor");
    a_div_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == GS_DIV && bit_cnt_reg == 5'd0)
        |=> (state_reg == GS_IDLE && sum_reg == '0 && count_reg == '0))
        else $error("accumulators not cleared after gain");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != GS_IDLE |-> !q_pop)
        else $error("pixel taken during gain computation");

endmodule

### design/luminance_brightness_normalizer.sv
// Path: an apply pixel is written into the queue, popped by the back end when it is idle
//   and the output is free, and scaled into the output register that drives m_tvalid.
// Throughput: one pixel per cycle while the queue has room; the last measure pixel starts
//   a gain computation (two multiplies, a range check, then a 32-step serial divider unless
//   the check saturates) during which the 4-entry queue fills and then stalls the input.
// Reset: synchronous, active low; registers return to target 32768, adjustment 4096,
//   empty accumulators and unity gain; no clearing pass.
module luminance_brightness_normalizer #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
    input  logic        s_tuser,   // action: 0 measure, 1 apply
    input  logic        s_tlast,   // last_of_pass
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lbn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import lbn_pkg::*;

    lbn_cfg_t  cfg_reg, cfg_next;
    lbn_item_t front_item, queue_item;
    logic      q_push, q_full, q_pop, q_valid;

    // Registers accept a transaction every cycle; an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET: cfg_next.target = cfg_data;
                REG_ADJUST: cfg_next.adjust = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target <= TARGET_RESET;
            cfg_reg.adjust <= ADJUST_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify the pixel and compute its luminance.
    lbn_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (front_item)
    );

    // Queue: hold pixels while the back end computes the gain or the output stalls.
    lbn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (queue_item)
    );

    // Back: accumulate, compute the gain, scale apply pixels.
    lbn_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (queue_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
